/* hw/rtl/mhnt_pkg.sv */
// Shared types and constants for the held-note tracker.
// Used by the front end, command queue, back end and top level.
package mhnt_pkg;

  // Operation codes on the input channel
  typedef enum logic [2:0] {
    OP_UMP     = 3'd0,
    OP_BYTE    = 3'd1,
    OP_QUERY   = 3'd2,
    OP_CONSUME = 3'd3,
    OP_CLEAR   = 3'd4
  } op_t;

  // Commands handed from the front end to the back end
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_SET,
    CMD_CLR_BIT,
    CMD_CLR_CHAN,
    CMD_CLR_SRC,
    CMD_QUERY,
    CMD_CONSUME,
    CMD_CLR_ALL
  } cmd_kind_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    BE_IDLE,
    BE_READ,
    BE_WALK,
    BE_EMIT
  } be_state_t;

  // Widest bitmap word index over the parameter range
  localparam int ADDR_MAX_BITS = 15;

  // Message status nibbles and special values
  localparam logic [3:0] ST_NOTE_OFF = 4'h8;
  localparam logic [3:0] ST_NOTE_ON  = 4'h9;
  localparam logic [3:0] ST_CTRL     = 4'hB;
  localparam logic [3:0] ST_PROG     = 4'hC;
  localparam logic [3:0] ST_CHPRESS  = 4'hD;
  localparam logic [3:0] UMP_SYSTEM  = 4'h1;
  localparam logic [3:0] UMP_VOICE1  = 4'h2;
  localparam logic [3:0] UMP_VOICE2  = 4'h4;
  localparam logic [6:0] CC_SOUND_OFF = 7'd120;
  localparam logic [6:0] CC_NOTES_OFF = 7'd123;
  localparam logic [7:0] BYTE_RESET  = 8'hFF;
  localparam logic [7:0] BYTE_SYSEX  = 8'hF0;
  localparam logic [7:0] BYTE_SYSTEM = 8'hF0;

  typedef struct packed {
    cmd_kind_t                 kind;
    logic                      record;
    logic [6:0]                note;
    logic [5:0]                bit_pos;
    logic [ADDR_MAX_BITS-1:0]  addr;
  } cmd_t;

  // Words in a UMP message by message type
  function automatic logic [2:0] ump_len(input logic [3:0] mt);
    logic [2:0] n;
    unique case (mt)
      4'h0, 4'h1, 4'h2, 4'h6, 4'h7: n = 3'd1;
      4'h3, 4'h4, 4'h8, 4'h9, 4'hA: n = 3'd2;
      4'hB, 4'hC:                   n = 3'd3;
      default:                      n = 3'd4;
    endcase
    return n;
  endfunction

endpackage

/* hw/rtl/midi_held_note_tracker.sv */
// Held-note tracker: top level joining front end, command queue and back end.
// Depends on mhnt_pkg, mhnt_front, mhnt_cmdq, mhnt_back.
//
// Input channel (in_valid/in_stall) takes one item per accepted cycle: a UMP
// word, a MIDI 1.0 byte, a note query, a consume of the pending record or a
// clear of everything. The front end assembles messages at one item per
// accepted cycle and queues one command per item in a two-entry queue.
// Output channel (out_valid/out_stall) returns exactly one result per item,
// in order, from a result register.
// In the back end, items that leave the bitmap alone give their result from
// idle; a note on or note off reads its RAM word, then writes it and gives the
// result, and a query reads the word and gives the result; a channel clear
// walks two words, a source clear GROUPS*CHANNELS*2 words (512 by default) and
// clear-all SOURCES*GROUPS*CHANNELS*2 words (4096 by default): the back end
// walks the bitmap RAM one word per cycle on its single port pair.
// After reset the back end sweeps the whole bitmap RAM, SOURCES*GROUPS*
// CHANNELS*2 words (4096 by default); items are queued meanwhile and
// in_stall rises once the queue is full.
// When out_stall is high the result is held, the back end stops at its next
// result and the queue then fills and stalls the input.
module midi_held_note_tracker import mhnt_pkg::*; #(
  parameter int SOURCES    = 8,
  parameter int GROUPS     = 16,
  parameter int CHANNELS   = 16,
  parameter int COUNT_BITS = 56
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation,
  input  logic [2:0]  source_index,
  input  logic [31:0] data,
  input  logic        last,
  input  logic [3:0]  query_group,
  input  logic [3:0]  query_channel,
  input  logic [6:0]  query_note,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        note_held,
  output logic        any_held,
  output logic        pending_valid,
  output logic [6:0]  pending_note,
  output logic [55:0] pending_count
);

  logic accept;
  cmd_t front_cmd;
  cmd_t head_cmd;
  logic q_empty;
  logic q_full;
  logic pop;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  mhnt_front #(
    .SOURCES  (SOURCES),
    .GROUPS   (GROUPS),
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .operation     (operation),
    .source_index  (source_index),
    .data          (data),
    .last          (last),
    .query_group   (query_group),
    .query_channel (query_channel),
    .query_note    (query_note),
    .cmd           (front_cmd)
  );

  mhnt_cmdq u_cmdq (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_cmd (front_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .empty    (q_empty),
    .full     (q_full)
  );

  mhnt_back #(
    .SOURCES    (SOURCES),
    .GROUPS     (GROUPS),
    .CHANNELS   (CHANNELS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head_cmd      (head_cmd),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .note_held     (note_held),
    .any_held      (any_held),
    .pending_valid (pending_valid),
    .pending_note  (pending_note),
    .pending_count (pending_count)
  );

endmodule

/* hw/rtl/mhnt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mhnt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/mhnt_front.sv */
// Front end: assembles UMP words and MIDI 1.0 bytes into messages and
// turns every accepted item into one command. Depends on mhnt_pkg.
module mhnt_front import mhnt_pkg::*; #(
  parameter int SOURCES  = 8,
  parameter int GROUPS   = 16,
  parameter int CHANNELS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [2:0] operation,
  input  logic [2:0] source_index,
  input  logic [31:0] data,
  input  logic       last,
  input  logic [3:0] query_group,
  input  logic [3:0] query_channel,
  input  logic [6:0] query_note,
  output cmd_t       cmd
);

  localparam int WPS = GROUPS * CHANNELS * 2;

  logic [31:0] head;
  logic [31:0] head_next;
  logic        vel_zero;
  logic        vel_zero_next;
  logic [1:0]  wsn;
  logic [1:0]  wsn_next;
  logic [7:0]  bst;
  logic [7:0]  bst_next;
  logic [6:0]  bfd;
  logic [6:0]  bfd_next;
  logic [1:0]  bsn;
  logic [1:0]  bsn_next;
  logic        halt;
  logic        halt_next;

  // Hold assembly state
  always_ff @(posedge clk) begin
    if (rst) begin
      head     <= '0;
      vel_zero <= 1'b0;
      wsn      <= '0;
      bst      <= '0;
      bfd      <= '0;
      bsn      <= '0;
      halt     <= 1'b0;
    end else if (accept) begin
      head     <= head_next;
      vel_zero <= vel_zero_next;
      wsn      <= wsn_next;
      bst      <= bst_next;
      bfd      <= bfd_next;
      bsn      <= bsn_next;
      halt     <= halt_next;
    end
  end

  // Assemble messages and classify
  always_comb begin
    logic       v_go;
    logic [3:0] v_status;
    logic [6:0] v_d1;
    logic       v_vz;
    logic [3:0] v_grp;
    logic [3:0] v_ch;
    logic       clr_src;
    logic [2:0] len;
    logic       vzv;
    logic [7:0] b;
    logic       two;
    logic       ok;
    int         base;

    head_next     = head;
    vel_zero_next = vel_zero;
    wsn_next      = wsn;
    bst_next      = bst;
    bfd_next      = bfd;
    bsn_next      = bsn;
    halt_next     = halt;
    v_go     = 1'b0;
    v_status = '0;
    v_d1     = '0;
    v_vz     = 1'b0;
    v_grp    = '0;
    v_ch     = '0;
    clr_src  = 1'b0;
    len      = '0;
    vzv      = vel_zero;
    b        = data[7:0];
    two      = 1'b0;
    ok       = 1'b0;
    base     = 0;
    cmd      = '0;
    cmd.kind = CMD_NONE;

    unique case (operation)
      OP_UMP: begin
        if (wsn == 2'd0) begin
          len = ump_len(data[31:28]);
          if (len == 3'd1) begin
            if (data[31:28] == UMP_SYSTEM) begin
              clr_src = (data[23:16] == BYTE_RESET);
            end else if (data[31:28] == UMP_VOICE1) begin
              v_go     = 1'b1;
              v_grp    = data[27:24];
              v_ch     = data[19:16];
              v_status = data[23:20];
              v_d1     = data[14:8];
              v_vz     = (data[6:0] == 7'd0);
            end
          end else begin
            head_next = data;
            wsn_next  = 2'(len - 3'd1);
          end
        end else begin
          len = ump_len(head[31:28]);
          if ({1'b0, wsn} == len - 3'd1) begin
            vzv = (data[31:16] == 16'd0);
          end
          vel_zero_next = vzv;
          wsn_next      = wsn - 2'd1;
          if (wsn == 2'd1 && head[31:28] == UMP_VOICE2) begin
            v_go     = 1'b1;
            v_grp    = head[27:24];
            v_ch     = head[19:16];
            v_status = head[23:20];
            v_d1     = head[14:8];
            v_vz     = vzv;
          end
        end
      end
      OP_BYTE: begin
        if (!halt) begin
          if (b[7]) begin
            bst_next = '0;
            bsn_next = '0;
            if (b >= BYTE_SYSTEM) begin
              if (b == BYTE_RESET) begin
                clr_src = 1'b1;
              end else if (b == BYTE_SYSEX) begin
                halt_next = 1'b1;
              end
            end else begin
              bst_next = b;
              bsn_next = (b[7:4] == ST_PROG || b[7:4] == ST_CHPRESS) ? 2'd1 : 2'd2;
            end
          end else if (bst != 8'd0) begin
            if (bsn == 2'd2) begin
              bfd_next = b[6:0];
              bsn_next = 2'd1;
            end else begin
              two      = !(bst[7:4] == ST_PROG || bst[7:4] == ST_CHPRESS);
              v_go     = 1'b1;
              v_grp    = '0;
              v_ch     = bst[3:0];
              v_status = bst[7:4];
              v_d1     = two ? bfd : b[6:0];
              v_vz     = two ? (b[6:0] == 7'd0) : 1'b1;
              bst_next = '0;
              bsn_next = '0;
            end
          end
        end
      end
      OP_QUERY: begin
        ok = (int'(source_index) < SOURCES) && (int'(query_group) < GROUPS) &&
             (int'(query_channel) < CHANNELS);
        base = ((int'(source_index) * GROUPS + int'(query_group)) * CHANNELS +
                int'(query_channel)) * 2;
        if (ok) begin
          cmd.kind    = CMD_QUERY;
          cmd.addr    = ADDR_MAX_BITS'(base + int'(query_note[6]));
          cmd.bit_pos = query_note[5:0];
        end
      end
      OP_CONSUME: cmd.kind = CMD_CONSUME;
      OP_CLEAR:   cmd.kind = CMD_CLR_ALL;
      default:    cmd.kind = CMD_NONE;
    endcase

    // Map a completed voice message onto a bitmap command
    if (v_go) begin
      ok = (int'(source_index) < SOURCES) && (int'(v_grp) < GROUPS) &&
           (int'(v_ch) < CHANNELS);
      base = ((int'(source_index) * GROUPS + int'(v_grp)) * CHANNELS + int'(v_ch)) * 2;
      cmd.addr    = ADDR_MAX_BITS'(base + int'(v_d1[6]));
      cmd.bit_pos = v_d1[5:0];
      if (v_status == ST_NOTE_OFF || (v_status == ST_NOTE_ON && v_vz)) begin
        cmd.kind = ok ? CMD_CLR_BIT : CMD_NONE;
      end else if (v_status == ST_NOTE_ON) begin
        cmd.kind   = ok ? CMD_SET : CMD_NONE;
        cmd.record = 1'b1;
        cmd.note   = v_d1;
      end else if (v_status == ST_CTRL && (v_d1 == CC_SOUND_OFF || v_d1 == CC_NOTES_OFF)) begin
        cmd.kind = ok ? CMD_CLR_CHAN : CMD_NONE;
        cmd.addr = ADDR_MAX_BITS'(base);
      end
    end

    if (clr_src && int'(source_index) < SOURCES) begin
      cmd.kind = CMD_CLR_SRC;
      cmd.addr = ADDR_MAX_BITS'(int'(source_index) * WPS);
    end

    // Drop partial messages at packet end
    if (last && (operation == OP_UMP || operation == OP_BYTE)) begin
      head_next     = '0;
      vel_zero_next = 1'b0;
      wsn_next      = '0;
      bst_next      = '0;
      bfd_next      = '0;
      bsn_next      = '0;
      halt_next     = 1'b0;
    end
  end

endmodule

/* hw/rtl/mhnt_cmdq.sv */
// Two-entry command queue between the front and back ends.
// Depends on mhnt_pkg.
module mhnt_cmdq import mhnt_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t head_cmd,
  output logic empty,
  output logic full
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign head_cmd = slots[rd_ptr];
  assign empty    = (fill == 2'd0);
  assign full     = (fill == 2'd2);

  // Store pushed items
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop);
    end
  end

endmodule

/* hw/rtl/mhnt_back.sv */
// Back end: carries out bitmap commands on the held-note RAM, keeps the
// pending record and drives the result register. Depends on mhnt_pkg, mhnt_ram.
module mhnt_back import mhnt_pkg::*; #(
  parameter int SOURCES    = 8,
  parameter int GROUPS     = 16,
  parameter int CHANNELS   = 16,
  parameter int COUNT_BITS = 56
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        head_cmd,
  input  logic        empty,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        note_held,
  output logic        any_held,
  output logic        pending_valid,
  output logic [6:0]  pending_note,
  output logic [55:0] pending_count
);

  localparam int WPS   = GROUPS * CHANNELS * 2;
  localparam int DEPTH = SOURCES * WPS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = AW + 1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  be_state_t             state, state_next;
  cmd_t                  cur, cur_next;
  logic [AW-1:0]         wptr, wptr_next;
  logic [AW-1:0]         remaining, remaining_next;
  logic                  walk_count, walk_count_next;
  logic                  walk_emit, walk_emit_next;
  logic [CW-1:0]         count, count_next;
  logic [7:0]            lp1, lp1_next;
  logic [COUNT_BITS-1:0] on_cnt, on_cnt_next;
  logic                  res_held, res_held_next;
  logic                  res_pv, res_pv_next;
  logic [6:0]            res_note, res_note_next;
  logic [COUNT_BITS-1:0] res_pcount, res_pcount_next;
  logic                  out_valid_next;

  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [63:0]           wr_data;
  logic [AW-1:0]         rd_addr;
  logic [63:0]           rd_data;

  mhnt_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Control registers; reset starts the clearing pass over the RAM
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= BE_WALK;
      wptr       <= '0;
      remaining  <= AW'(DEPTH - 1);
      walk_count <= 1'b0;
      walk_emit  <= 1'b0;
      count      <= '0;
      lp1        <= '0;
      on_cnt     <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      wptr       <= wptr_next;
      remaining  <= remaining_next;
      walk_count <= walk_count_next;
      walk_emit  <= walk_emit_next;
      count      <= count_next;
      lp1        <= lp1_next;
      on_cnt     <= on_cnt_next;
      out_valid  <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur        <= cur_next;
    res_held   <= res_held_next;
    res_pv     <= res_pv_next;
    res_note   <= res_note_next;
    res_pcount <= res_pcount_next;
  end

  // Sequence commands, update bitmap, count and pending record
  always_comb begin
    logic                  out_free;
    logic                  finish;
    logic                  e_held;
    logic                  e_pv;
    logic [6:0]            e_note;
    logic [COUNT_BITS-1:0] e_pcount;
    logic                  rec;
    logic [6:0]            rec_note;
    logic [63:0]           mask;
    logic [63:0]           nw;

    state_next      = state;
    cur_next        = cur;
    wptr_next       = wptr;
    remaining_next  = remaining;
    walk_count_next = walk_count;
    walk_emit_next  = walk_emit;
    count_next      = count;
    lp1_next        = lp1;
    on_cnt_next     = on_cnt;
    res_held_next   = res_held;
    res_pv_next     = res_pv;
    res_note_next   = res_note;
    res_pcount_next = res_pcount;
    out_free        = !out_valid || !out_stall;
    out_valid_next  = out_valid && out_stall;
    pop      = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = wptr;
    wr_data  = '0;
    rd_addr  = wptr;
    finish   = 1'b0;
    e_held   = 1'b0;
    e_pv     = 1'b0;
    e_note   = '0;
    e_pcount = '0;
    rec      = 1'b0;
    rec_note = '0;
    mask     = 64'd1 << cur.bit_pos;
    nw       = '0;

    unique case (state)
      BE_IDLE: begin
        if (!empty) begin
          pop      = 1'b1;
          cur_next = head_cmd;
          unique case (head_cmd.kind)
            CMD_SET, CMD_CLR_BIT, CMD_QUERY: begin
              rd_addr    = head_cmd.addr[AW-1:0];
              state_next = BE_READ;
            end
            CMD_CLR_CHAN: begin
              rd_addr         = head_cmd.addr[AW-1:0];
              wptr_next       = head_cmd.addr[AW-1:0];
              remaining_next  = AW'(1);
              walk_count_next = 1'b1;
              walk_emit_next  = 1'b1;
              state_next      = BE_WALK;
            end
            CMD_CLR_SRC: begin
              rd_addr         = head_cmd.addr[AW-1:0];
              wptr_next       = head_cmd.addr[AW-1:0];
              remaining_next  = AW'(WPS - 1);
              walk_count_next = 1'b1;
              walk_emit_next  = 1'b1;
              state_next      = BE_WALK;
            end
            CMD_CLR_ALL: begin
              wptr_next       = '0;
              remaining_next  = AW'(DEPTH - 1);
              walk_count_next = 1'b0;
              walk_emit_next  = 1'b1;
              count_next      = '0;
              lp1_next        = '0;
              on_cnt_next     = '0;
              state_next      = BE_WALK;
            end
            CMD_CONSUME: begin
              e_pv = (lp1 != 8'd0);
              if (e_pv) begin
                e_note   = 7'(lp1 - 8'd1);
                e_pcount = on_cnt;
              end
              lp1_next    = '0;
              on_cnt_next = '0;
              finish      = 1'b1;
            end
            default: begin
              rec      = head_cmd.record;
              rec_note = head_cmd.note;
              finish   = 1'b1;
            end
          endcase
        end
      end
      BE_READ: begin
        if (cur.kind == CMD_QUERY) begin
          e_held = rd_data[cur.bit_pos];
        end else begin
          nw = (cur.kind == CMD_SET) ? (rd_data | mask) : (rd_data & ~mask);
          wr_en   = 1'b1;
          wr_addr = cur.addr[AW-1:0];
          wr_data = nw;
          if (rd_data != 64'd0 && nw == 64'd0) begin
            count_next = count - CW'(1);
          end else if (rd_data == 64'd0 && nw != 64'd0) begin
            count_next = count + CW'(1);
          end
          rec      = cur.record;
          rec_note = cur.note;
        end
        finish = 1'b1;
      end
      BE_WALK: begin
        wr_en   = 1'b1;
        wr_addr = wptr;
        if (walk_count && rd_data != 64'd0) begin
          count_next = count - CW'(1);
        end
        if (remaining != '0) begin
          wptr_next      = wptr + AW'(1);
          remaining_next = remaining - AW'(1);
          rd_addr        = wptr + AW'(1);
        end else if (walk_emit) begin
          finish = 1'b1;
        end else begin
          state_next = BE_IDLE;
        end
      end
      BE_EMIT: begin
        if (out_free) begin
          out_valid_next = 1'b1;
          state_next     = BE_IDLE;
        end
      end
      default: state_next = BE_IDLE;
    endcase

    // Record a note-on
    if (rec) begin
      if (on_cnt != COUNT_MAX) begin
        on_cnt_next = on_cnt + COUNT_BITS'(1);
      end
      lp1_next = {1'b0, rec_note} + 8'd1;
    end

    // Hand the result to the output register, or hold it until free
    if (finish) begin
      res_held_next   = e_held;
      res_pv_next     = e_pv;
      res_note_next   = e_note;
      res_pcount_next = e_pcount;
      if (out_free) begin
        out_valid_next = 1'b1;
        state_next     = BE_IDLE;
      end else begin
        state_next = BE_EMIT;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (out_valid_next && !(out_valid && out_stall)) begin
      note_held     <= res_held_next;
      any_held      <= (count_next != '0);
      pending_valid <= res_pv_next;
      pending_note  <= res_note_next;
      pending_count <= 56'(res_pcount_next);
    end
  end

endmodule

/* verif/midi_held_note_tracker_tb.sv */
// Self-checking testbench for midi_held_note_tracker: a directed table, then random
// UMP and MIDI 1.0 packets, queries and consumes, checked by an in-bench tracker
// (typed rows expect zeros). Depends on mhnt_pkg and the midi_held_note_tracker RTL.
module midi_held_note_tracker_tb import mhnt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_ITEMS = 1700;
  localparam int QUIET_FROM = 1500;
  localparam int SRC_WORDS = 16 * 16 * 2;
  localparam int ALL_WORDS = 8 * SRC_WORDS;

  typedef struct {
    op_t         op;
    logic [2:0]  src;
    logic [31:0] data;
    logic        last;
    logic [3:0]  qg;
    logic [3:0]  qc;
    logic [6:0]  qn;
  } stim_t;

  typedef struct {
    logic        held;
    logic        any;
    logic        pvalid;
    logic [6:0]  pnote;
    logic [55:0] pcount;
  } answer_t;

  typedef struct {
    stim_t   s;
    bit      typed;
    answer_t a;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  operation = '0;
  logic [2:0]  source_index = '0;
  logic [31:0] data = '0;
  logic        last = 1'b0;
  logic [3:0]  query_group = '0;
  logic [3:0]  query_channel = '0;
  logic [6:0]  query_note = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        note_held;
  logic        any_held;
  logic        pending_valid;
  logic [6:0]  pending_note;
  logic [55:0] pending_count;

  midi_held_note_tracker dut (.*);

  always #6 clk = ~clk;

  // Tracker state
  logic [63:0] held_words [0:ALL_WORDS-1];
  int          set_words;
  logic [7:0]  latest_p1;
  logic [55:0] on_count;
  logic [31:0] head_word;
  logic [15:0] vel_half;
  int          words_left;
  logic [7:0]  run_status;
  logic [6:0]  first_byte;
  int          bytes_left;
  bit          halted;

  answer_t answer_q[$];
  int      n_items, n_results, n_errors, n_held_hits, n_pending_hits;
  bit      quiet;
  int      stall_left;

  // Words in a UMP message by message type
  function automatic int msg_words(logic [3:0] mt);
    case (mt)
      4'h0, 4'h1, 4'h2, 4'h6, 4'h7: return 1;
      4'h3, 4'h4, 4'h8, 4'h9, 4'hA: return 2;
      4'hB, 4'hC:                   return 3;
      default:                      return 4;
    endcase
  endfunction

  // Append to the stimulus list or the directed table
  task automatic add_stim(ref stim_t q[$], input stim_t s);
    q.insert(q.size(), s);
  endtask

  task automatic add_row(ref row_t q[$], input stim_t s, input bit typed);
    row_t r;
    r.s = s;
    r.typed = typed;
    r.a = '{default: '0};
    q.insert(q.size(), r);
  endtask

  task automatic put_word(int idx, logic [63:0] v);
    if (held_words[idx] != 0 && v == 0) set_words--;
    else if (held_words[idx] == 0 && v != 0) set_words++;
    held_words[idx] = v;
  endtask

  task automatic clear_source(logic [2:0] src);
    for (int i = 0; i < SRC_WORDS; i++) put_word(src * SRC_WORDS + i, '0);
  endtask

  // Apply one channel voice message to the bitmap and pending record
  task automatic apply_voice(logic [2:0] src, logic [3:0] grp, logic [3:0] ch,
                             logic [3:0] st, logic [6:0] d1, bit vel_zero);
    int base, idx;
    logic [63:0] mask;
    base = ((src * 16 + grp) * 16 + ch) * 2;
    idx = base + d1[6];
    mask = 64'd1 << d1[5:0];
    if (st == ST_NOTE_OFF || (st == ST_NOTE_ON && vel_zero)) begin
      put_word(idx, held_words[idx] & ~mask);
    end else if (st == ST_NOTE_ON) begin
      put_word(idx, held_words[idx] | mask);
      if (on_count != '1) on_count++;
      latest_p1 = {1'b0, d1} + 8'd1;
    end else if (st == ST_CTRL && (d1 == CC_SOUND_OFF || d1 == CC_NOTES_OFF)) begin
      put_word(base, '0);
      put_word(base + 1, '0);
    end
  endtask

  task automatic ump_in(logic [2:0] src, logic [31:0] w);
    int len;
    if (words_left == 0) begin
      len = msg_words(w[31:28]);
      if (len == 1) begin
        if (w[31:28] == UMP_SYSTEM && w[23:16] == BYTE_RESET) clear_source(src);
        else if (w[31:28] == UMP_VOICE1)
          apply_voice(src, w[27:24], w[19:16], w[23:20], w[14:8], w[6:0] == 0);
      end else begin
        head_word = w;
        words_left = len - 1;
      end
      return;
    end
    len = msg_words(head_word[31:28]);
    if (words_left == len - 1) vel_half = w[31:16];
    words_left--;
    if (words_left == 0 && head_word[31:28] == UMP_VOICE2)
      apply_voice(src, head_word[27:24], head_word[19:16], head_word[23:20],
                  head_word[14:8], vel_half == 0);
  endtask

  task automatic byte_in(logic [2:0] src, logic [7:0] b);
    bit two;
    logic [6:0] d1, d2;
    if (halted) return;
    if (b[7]) begin
      run_status = '0;
      bytes_left = 0;
      if (b >= BYTE_SYSTEM) begin
        if (b == BYTE_RESET) clear_source(src);
        else if (b == BYTE_SYSEX) halted = 1;
        return;
      end
      run_status = b;
      bytes_left = (b[7:4] == ST_PROG || b[7:4] == ST_CHPRESS) ? 1 : 2;
      return;
    end
    if (run_status == 0) return;
    if (bytes_left == 2) begin
      first_byte = b[6:0];
      bytes_left = 1;
      return;
    end
    two = !(run_status[7:4] == ST_PROG || run_status[7:4] == ST_CHPRESS);
    d1 = two ? first_byte : b[6:0];
    d2 = two ? b[6:0] : 7'd0;
    apply_voice(src, 4'd0, run_status[3:0], run_status[7:4], d1, d2 == 0);
    run_status = '0;
    bytes_left = 0;
  endtask

  // Advance the tracker by one item and return its answer
  task automatic track_item(stim_t s, output answer_t r);
    int base;
    r = '{default: '0};
    case (s.op)
      OP_UMP, OP_BYTE: begin
        if (s.op == OP_UMP) ump_in(s.src, s.data);
        else byte_in(s.src, s.data[7:0]);
        if (s.last) begin
          head_word = '0; vel_half = '0; words_left = 0;
          run_status = '0; first_byte = '0; bytes_left = 0; halted = 0;
        end
      end
      OP_QUERY: begin
        base = ((s.src * 16 + s.qg) * 16 + s.qc) * 2;
        r.held = held_words[base + s.qn[6]][s.qn[5:0]];
      end
      OP_CONSUME: begin
        if (latest_p1 != 0) begin
          r.pvalid = 1'b1;
          r.pnote = latest_p1[6:0] - 7'd1;
          r.pcount = on_count;
        end
        latest_p1 = '0;
        on_count = '0;
      end
      OP_CLEAR: begin
        for (int i = 0; i < ALL_WORDS; i++) held_words[i] = '0;
        set_words = 0;
        latest_p1 = '0;
        on_count = '0;
      end
      default: ;
    endcase
    r.any = set_words != 0;
  endtask

  // Drive one item, wait for acceptance, then queue its answer
  task automatic send_item(stim_t s, bit typed = 0, answer_t typed_a = '{default: '0});
    answer_t a;
    if (!quiet && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    operation <= s.op;
    source_index <= s.src;
    data <= s.data;
    last <= s.last;
    query_group <= s.qg;
    query_channel <= s.qc;
    query_note <= s.qn;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    track_item(s, a);
    answer_q.insert(answer_q.size(), typed ? typed_a : a);
    n_items++;
  endtask

  function automatic stim_t mk(op_t op, logic [2:0] src, logic [31:0] d, logic lst,
                               logic [3:0] qg = 0, logic [3:0] qc = 0, logic [6:0] qn = 0);
    stim_t s;
    s = '{op, src, d, lst, qg, qc, qn};
    return s;
  endfunction

  // Bias notes, groups, channels and sources so that queries find held notes
  function automatic logic [6:0] pick_note();
    return $urandom_range(0, 1) ? 7'($urandom_range(58, 69)) : 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [3:0] pick_nib();
    return $urandom_range(0, 3) != 0 ? 4'($urandom_range(0, 1)) : 4'($urandom_range(0, 15));
  endfunction

  function automatic logic [2:0] pick_src();
    return $urandom_range(0, 1) ? 3'($urandom_range(0, 1)) : 3'($urandom_range(0, 7));
  endfunction

  function automatic logic [3:0] pick_status();
    case ($urandom_range(0, 5))
      0, 1:    return ST_NOTE_ON;
      2:       return ST_NOTE_OFF;
      3:       return ST_CTRL;
      default: return 4'($urandom_range(8, 15));
    endcase
  endfunction

  function automatic logic [6:0] pick_ctrl_or_note(logic [3:0] st);
    if (st == ST_CTRL && $urandom_range(0, 1))
      return $urandom_range(0, 1) ? CC_SOUND_OFF : CC_NOTES_OFF;
    return pick_note();
  endfunction

  // Build one random packet or command
  task automatic random_packet(ref stim_t pk[$]);
    int r, len;
    logic [2:0] src;
    logic [3:0] st, mt;
    logic [6:0] nt;
    logic [31:0] w;
    r = $urandom_range(0, 99);
    src = pick_src();
    st = pick_status();
    nt = pick_ctrl_or_note(st);
    if (r < 30) begin
      w = {UMP_VOICE1, pick_nib(), st, pick_nib(), 1'($urandom), nt, 1'($urandom),
           $urandom_range(0, 3) == 0 ? 7'd0 : 7'($urandom)};
      add_stim(pk, mk(OP_UMP, src, w, $urandom_range(0, 3) != 0));
    end else if (r < 42) begin
      w = {UMP_VOICE2, pick_nib(), st, pick_nib(), 1'($urandom), nt, 8'($urandom)};
      add_stim(pk, mk(OP_UMP, src, w, $urandom_range(0, 9) == 0));
      w = {$urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom), 16'($urandom)};
      add_stim(pk, mk(OP_UMP, src, w, $urandom_range(0, 3) != 0));
    end else if (r < 48) begin
      mt = 4'($urandom);
      len = msg_words(mt);
      for (int i = 0; i < len; i++) begin
        w = $urandom;
        if (i == 0) w[31:28] = mt;
        add_stim(pk, mk(OP_UMP, src, w, i == len - 1 && $urandom_range(0, 3) != 0));
      end
    end else if (r < 49) begin
      w = {UMP_SYSTEM, 4'($urandom), $urandom_range(0, 1) ? BYTE_RESET : 8'($urandom),
           16'($urandom)};
      add_stim(pk, mk(OP_UMP, src, w, 1'b1));
    end else if (r < 70) begin
      if ($urandom_range(0, 5) == 0) st = 4'($urandom_range(8, 14));
      len = (st == ST_PROG || st == ST_CHPRESS) ? 1 : 2;
      add_stim(pk, mk(OP_BYTE, src, {24'($urandom), st, pick_nib()}, 1'b0));
      if ($urandom_range(0, 9) == 0)
        add_stim(pk, mk(OP_BYTE, src, {24'($urandom), 8'($urandom_range(128, 239))}, 1'b0));
      add_stim(pk, mk(OP_BYTE, src, {24'($urandom), 1'b0, nt}, len == 1));
      if (len == 2)
        add_stim(pk, mk(OP_BYTE, src, {24'($urandom), 1'b0,
                        $urandom_range(0, 3) == 0 ? 7'd0 : 7'($urandom)},
                        $urandom_range(0, 3) != 0));
    end else if (r < 72) begin
      add_stim(pk, mk(OP_BYTE, src, {24'($urandom), BYTE_SYSEX}, 1'b0));
      len = $urandom_range(1, 3);
      for (int i = 0; i < len; i++)
        add_stim(pk, mk(OP_BYTE, src, $urandom, i == len - 1));
    end else if (r < 73) begin
      add_stim(pk, mk(OP_BYTE, src, {24'($urandom), BYTE_RESET}, 1'($urandom)));
    end else if (r < 78) begin
      w = $urandom;
      if (w[7:0] == BYTE_RESET) w[0] = 1'b0;
      add_stim(pk, mk(OP_BYTE, src, w, 1'($urandom)));
    end else if (r < 88) begin
      add_stim(pk, mk(OP_QUERY, src, $urandom, 1'($urandom), pick_nib(), pick_nib(),
                      pick_note()));
    end else if (r < 96) begin
      add_stim(pk, mk(OP_CONSUME, src, $urandom, 1'($urandom), 4'($urandom), 4'($urandom),
                      7'($urandom)));
    end else if (r == 96) begin
      add_stim(pk, mk(OP_CLEAR, src, $urandom, 1'($urandom)));
    end else begin
      add_stim(pk, mk(OP_UMP, src, $urandom, 1'($urandom)));
    end
  endtask

  // Stall the result channel in random bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      stall_left <= 0;
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 11) == 0) begin
      stall_left <= $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic check_field(string name, logic [55:0] e, logic [55:0] a);
    if (e !== a) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, e, a);
      n_errors++;
    end
  endtask

  // Compare each accepted result with the oldest answer
  always @(posedge clk) begin
    answer_t e;
    if (!rst && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        $display("%0t: result with no item outstanding", $realtime);
        n_errors++;
      end else begin
        e = answer_q.pop_front();
        check_field("note_held", e.held, note_held);
        check_field("any_held", e.any, any_held);
        check_field("pending_valid", e.pvalid, pending_valid);
        check_field("pending_note", e.pnote, pending_note);
        check_field("pending_count", e.pcount, pending_count);
        n_results++;
        if (e.held) n_held_hits++;
        if (e.pvalid) n_pending_hits++;
      end
    end
  end

  // Directed table, random packets, drain, verdict
  initial begin
    row_t rows[$];
    stim_t pk[$];
    bit paused;
    for (int i = 0; i < ALL_WORDS; i++) held_words[i] = '0;
    set_words = 0; latest_p1 = '0; on_count = '0; head_word = '0; vel_half = '0;
    words_left = 0; run_status = '0; first_byte = '0; bytes_left = 0; halted = 0;
    paused = 0;

    add_row(rows, mk(OP_QUERY, 0, 32'h0, 0, 0, 0, 0), 1);
    add_row(rows, mk(OP_CONSUME, 0, 32'h0, 0), 1);
    add_row(rows, mk(OP_UMP, 0, 32'h2090_3C64, 1), 0);
    add_row(rows, mk(OP_QUERY, 0, 32'h0, 0, 0, 0, 60), 0);
    add_row(rows, mk(OP_UMP, 7, 32'h4F9F_7F00, 0), 0);
    add_row(rows, mk(OP_UMP, 7, 32'hFFFF_FFFF, 1), 0);
    add_row(rows, mk(OP_QUERY, 7, 32'hFFFF_FFFF, 1, 15, 15, 127), 0);
    add_row(rows, mk(OP_CONSUME, 7, 32'h0, 1), 0);
    add_row(rows, mk(OP_BYTE, 3, 32'h0000_0090, 0), 0);
    add_row(rows, mk(OP_BYTE, 3, 32'h0000_0000, 0), 0);
    add_row(rows, mk(OP_BYTE, 3, 32'h0000_0040, 1), 0);
    add_row(rows, mk(OP_BYTE, 3, 32'h0000_0090, 0), 0);
    add_row(rows, mk(OP_BYTE, 3, 32'h0000_0000, 0), 0);
    add_row(rows, mk(OP_BYTE, 3, 32'h0000_0000, 1), 0);
    add_row(rows, mk(OP_UMP, 0, 32'h20B0_7B00, 1), 0);
    add_row(rows, mk(OP_BYTE, 1, 32'h0000_00F0, 0), 0);
    add_row(rows, mk(OP_BYTE, 1, 32'h0000_0091, 0), 0);
    add_row(rows, mk(OP_BYTE, 1, 32'h0000_0010, 1), 0);
    add_row(rows, mk(OP_UMP, 7, 32'h10FF_0000, 1), 0);
    add_row(rows, mk(OP_BYTE, 3, 32'hFFFF_FFFF, 1), 0);
    add_row(rows, mk(OP_UMP, 2, 32'hFFFF_FFFF, 1), 0);
    add_row(rows, mk(OP_BYTE, 2, 32'h0000_00C5, 0), 0);
    add_row(rows, mk(OP_BYTE, 2, 32'h0000_007F, 1), 0);
    add_row(rows, mk(OP_CLEAR, 0, 32'h0, 0), 1);
    add_row(rows, mk(OP_QUERY, 0, 32'h0, 0, 15, 15, 127), 1);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) send_item(rows[i].s, rows[i].typed, rows[i].a);

    while (n_items < NUM_ITEMS) begin
      // Hold off once until every answer is back
      if (!paused && n_items >= 800) begin
        in_valid <= 1'b0;
        while (answer_q.size() != 0) @(posedge clk);
        paused = 1;
      end
      if (n_items >= QUIET_FROM) quiet = 1;
      pk.delete();
      random_packet(pk);
      foreach (pk[i]) send_item(pk[i]);
    end
    in_valid <= 1'b0;

    while (answer_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d items and checked %0d results", n_items, n_results);
    $display("Held-note hits: %0d, pending records consumed: %0d",
             n_held_hits, n_pending_hits);
    if (n_errors == 0) begin
      $display("midi_held_note_tracker regression: pass");
    end else begin
      $display("midi_held_note_tracker regression: fail");
    end
    $finish;
  end

  // Give up if the run hangs
  initial begin
    #(12 * 800000);
    $display("midi_held_note_tracker regression: fail");
    $finish;
  end

endmodule
